@@ hdl/bsu_pkg.sv @@
package bsu_pkg;

    localparam int VALUE_W = 32;

    typedef logic [2:0]                 t_op;
    typedef logic [1:0]                 t_kind;
    typedef logic [1:0]                 t_err;
    typedef logic signed [VALUE_W-1:0]  t_value;

    localparam t_op OP_PUSH = 3'd0;
    localparam t_op OP_POP  = 3'd1;
    localparam t_op OP_PEEK = 3'd2;
    localparam t_op OP_SWAP = 3'd3;
    localparam t_op OP_DUMP = 3'd4;

    localparam t_kind KIND_PEEK  = 2'd0;
    localparam t_kind KIND_DUMP  = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    localparam t_err ERR_NONE       = 2'd0;
    localparam t_err ERR_POP_EMPTY  = 2'd0;
    localparam t_err ERR_PEEK_EMPTY = 2'd1;
    localparam t_err ERR_SWAP_SHORT = 2'd2;
    localparam t_err ERR_PUSH_FULL  = 2'd3;

endpackage

@@ hdl/bsu_ram.sv @@
module bsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bytecode_stack_unit.sv @@
// Channel  | Direction | Handshake              | Beat fields
// ---------+-----------+------------------------+---------------------------------------
// command  | in        | start high, busy low   | i_operation, i_push_value
// result   | out       | strobe, one cycle      | o_result_kind, o_result_value,
//          |           |                        | o_error_code, o_last
//
// Push and peek never raise busy. A pop of more than one entry and a swap pass
// through S_POP or S_SWAP: the top entry sits in a register, the entries below it
// in the RAM, and the new top or the second entry comes back through the RAM's
// registered read. A dump of n entries gives n beats, all but the top from RAM.
// Synchronous active-low reset empties the stack and clears the halt flag.
// After an error the unit halts; commands are still taken but do nothing.
// Results cannot be stalled; each is shown for one cycle only.
module bytecode_stack_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bsu_pkg::t_op         i_operation,
    input  bsu_pkg::t_value      i_push_value,
    output logic                 strobe,
    output bsu_pkg::t_kind       o_result_kind,
    output bsu_pkg::t_value      o_result_value,
    output bsu_pkg::t_err        o_error_code,
    output logic                 o_last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SWAP = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_halted, n_halted;
    bsu_pkg::t_value r_top, n_top;
    logic [AW-1:0]   r_ptr, n_ptr;

    logic            r_strobe, n_strobe;
    bsu_pkg::t_kind  r_kind, n_kind;
    bsu_pkg::t_value r_value, n_value;
    bsu_pkg::t_err   r_err, n_err;
    logic            r_last, n_last;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [bsu_pkg::VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [bsu_pkg::VALUE_W-1:0] ram_rdata;
    bsu_pkg::t_value             rd_value;

    logic [CW-1:0] cnt_m1, cnt_m2;

    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign rd_value = $signed(ram_rdata);

    bsu_ram #(
        .WIDTH (bsu_pkg::VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_halted  = r_halted;
        n_top     = r_top;
        n_ptr     = r_ptr;
        n_strobe  = 1'b0;
        n_kind    = r_kind;
        n_value   = r_value;
        n_err     = r_err;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_waddr = cnt_m1[AW-1:0];
        ram_wdata = $unsigned(r_top);
        ram_raddr = cnt_m2[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start && !r_halted) begin
                    case (i_operation)
                        bsu_pkg::OP_PUSH: begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                n_strobe = 1'b1;
                                n_kind   = bsu_pkg::KIND_ERROR;
                                n_value  = '0;
                                n_err    = bsu_pkg::ERR_PUSH_FULL;
                                n_last   = 1'b1;
                                n_halted = 1'b1;
                            end else begin
                                ram_we  = (r_count != '0);
                                n_top   = i_push_value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        bsu_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_kind   = bsu_pkg::KIND_ERROR;
                                n_value  = '0;
                                n_err    = bsu_pkg::ERR_POP_EMPTY;
                                n_last   = 1'b1;
                                n_halted = 1'b1;
                            end else begin
                                n_count = cnt_m1;
                                if (r_count != CW'(1)) begin
                                    n_state = S_POP;
                                end
                            end
                        end
                        bsu_pkg::OP_PEEK: begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            if (r_count == '0) begin
                                n_kind   = bsu_pkg::KIND_ERROR;
                                n_value  = '0;
                                n_err    = bsu_pkg::ERR_PEEK_EMPTY;
                                n_halted = 1'b1;
                            end else begin
                                n_kind  = bsu_pkg::KIND_PEEK;
                                n_value = r_top;
                                n_err   = bsu_pkg::ERR_NONE;
                            end
                        end
                        bsu_pkg::OP_SWAP: begin
                            if (r_count < CW'(2)) begin
                                n_strobe = 1'b1;
                                n_kind   = bsu_pkg::KIND_ERROR;
                                n_value  = '0;
                                n_err    = bsu_pkg::ERR_SWAP_SHORT;
                                n_last   = 1'b1;
                                n_halted = 1'b1;
                            end else begin
                                n_state = S_SWAP;
                            end
                        end
                        bsu_pkg::OP_DUMP: begin
                            if (r_count != '0) begin
                                n_strobe = 1'b1;
                                n_kind   = bsu_pkg::KIND_DUMP;
                                n_value  = r_top;
                                n_err    = bsu_pkg::ERR_NONE;
                                n_last   = (r_count == CW'(1));
                                if (r_count != CW'(1)) begin
                                    n_ptr   = cnt_m2[AW-1:0];
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_top   = rd_value;
                n_state = S_IDLE;
            end
            S_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_m2[AW-1:0];
                n_top     = rd_value;
                n_state   = S_IDLE;
            end
            S_DUMP: begin
                n_strobe  = 1'b1;
                n_kind    = bsu_pkg::KIND_DUMP;
                n_value   = rd_value;
                n_err     = bsu_pkg::ERR_NONE;
                n_last    = (r_ptr == '0);
                ram_raddr = r_ptr - AW'(1);
                if (r_ptr == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr - AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_halted <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_halted <= n_halted;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top   <= n_top;
        r_ptr   <= n_ptr;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_err   <= n_err;
        r_last  <= n_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign strobe         = r_strobe;
    assign o_result_kind  = r_kind;
    assign o_result_value = r_value;
    assign o_error_code   = r_err;
    assign o_last         = r_last;

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_kind == bsu_pkg::KIND_ERROR) |-> r_halted)
        else $error("error beat without halt");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("entry count beyond depth");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> !r_strobe)
        else $error("beat while halted");

    a_dump_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_kind == bsu_pkg::KIND_DUMP && r_last) |-> r_state == S_IDLE)
        else $error("dump ended without returning to idle");

    a_dump_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (CW'(r_ptr) < r_count))
        else $error("dump pointer outside stack");

endmodule

@@ test/stack_result_checker.sv @@
module stack_result_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  bsu_pkg::t_op      i_operation,
    input  bsu_pkg::t_value   i_push_value,
    input  logic              strobe,
    input  bsu_pkg::t_kind    i_result_kind,
    input  bsu_pkg::t_value   i_result_value,
    input  bsu_pkg::t_err     i_error_code,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending
);
    import bsu_pkg::*;

    typedef struct packed {
        t_kind  kind;
        t_value value;
        t_err   code;
        logic   last;
    } t_stack_beat;

    t_value      model_stack [STACK_DEPTH];
    int          model_depth;
    logic        model_halted;
    t_stack_beat result_queue [$];
    int          mismatches = 0;

    function automatic void queue_beat(input t_kind kind, input t_value value,
                                       input t_err code, input logic last);
        t_stack_beat b;
        b.kind  = kind;
        b.value = value;
        b.code  = code;
        b.last  = last;
        result_queue.push_back(b);
    endfunction

    function automatic void raise_error(input t_err code);
        model_halted = 1'b1;
        queue_beat(KIND_ERROR, '0, code, 1'b1);
    endfunction

    function automatic void apply_command(input t_op op, input t_value value);
        t_value tmp;
        if (model_halted)
            return;
        case (op)
            OP_PUSH: begin
                if (model_depth >= STACK_DEPTH) begin
                    raise_error(ERR_PUSH_FULL);
                end else begin
                    model_stack[model_depth] = value;
                    model_depth++;
                end
            end
            OP_POP: begin
                if (model_depth == 0)
                    raise_error(ERR_POP_EMPTY);
                else
                    model_depth--;
            end
            OP_PEEK: begin
                if (model_depth == 0)
                    raise_error(ERR_PEEK_EMPTY);
                else
                    queue_beat(KIND_PEEK, model_stack[model_depth-1], ERR_NONE, 1'b1);
            end
            OP_SWAP: begin
                if (model_depth < 2) begin
                    raise_error(ERR_SWAP_SHORT);
                end else begin
                    tmp                        = model_stack[model_depth-1];
                    model_stack[model_depth-1] = model_stack[model_depth-2];
                    model_stack[model_depth-2] = tmp;
                end
            end
            OP_DUMP: begin
                for (int i = model_depth; i > 0; i--)
                    queue_beat(KIND_DUMP, model_stack[i-1], ERR_NONE, i == 1);
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input longint exp, input longint act);
        if (exp != act) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_beat exp_beat;
        if (!i_rst_n) begin
            model_depth  = 0;
            model_halted = 1'b0;
            result_queue.delete();
        end else begin
            // predict first, then check any result beat seen in this cycle
            if (start && !busy)
                apply_command(i_operation, i_push_value);
            if (strobe) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with nothing outstanding: kind %0d value %0d",
                           i_result_kind, i_result_value);
                    mismatches++;
                end else begin
                    exp_beat = result_queue.pop_front();
                    check_field("result_kind", exp_beat.kind, i_result_kind);
                    check_field("result_value", exp_beat.value, i_result_value);
                    check_field("error_code", exp_beat.code, i_error_code);
                    check_field("last", exp_beat.last, i_last);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= result_queue.size();
    end

endmodule

@@ test/tb.sv @@
module tb;
    import bsu_pkg::*;

    localparam int  DEPTH        = 32;
    localparam int  RANDOM_ITEMS = 200;
    localparam int  QUIET_LIMIT  = 1000;
    localparam int  DRAIN_CYCLES = 50;
    localparam t_op OP_SPARE_LO  = 3'd5;
    localparam t_op OP_SPARE_MID = 3'd6;
    localparam t_op OP_SPARE_HI  = 3'd7;
    localparam int  MODE_FILL    = 0;
    localparam int  MODE_DRAIN   = 1;
    localparam int  MODE_MIXED   = 2;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_op    i_operation;
    t_value i_push_value;
    logic   strobe;
    t_kind  o_result_kind;
    t_value o_result_value;
    t_err   o_error_code;
    logic   o_last;
    int     fail_count;
    int     pending;
    int     quiet_cycles;
    int     depth_now;
    logic   no_idle;

    bytecode_stack_unit #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .strobe         (strobe),
        .o_result_kind  (o_result_kind),
        .o_result_value (o_result_value),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    stack_result_checker #(.STACK_DEPTH(DEPTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .strobe         (strobe),
        .i_result_kind  (o_result_kind),
        .i_result_value (o_result_value),
        .i_error_code   (o_error_code),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int gap_cycles();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return t_value'($urandom);
        endcase
    endfunction

    // legal op for the current depth, with a little spare-code noise
    function automatic t_op pick_op(input int mode, input int depth);
        int push_weight;
        t_op op;
        if ($urandom_range(0, 99) < 4)
            return t_op'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        push_weight = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 15 : 40;
        if ($urandom_range(0, 99) < push_weight) begin
            op = OP_PUSH;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: op = OP_POP;
                3, 4:    op = OP_PEEK;
                5, 6, 7: op = OP_SWAP;
                default: op = OP_DUMP;
            endcase
            if (mode == MODE_DRAIN && $urandom_range(0, 1) == 0)
                op = OP_POP;
        end
        if ((op == OP_PUSH && depth >= DEPTH) ||
            ((op == OP_POP || op == OP_PEEK) && depth == 0) ||
            (op == OP_SWAP && depth < 2))
            op = (depth < DEPTH) ? OP_PUSH : OP_DUMP;
        return op;
    endfunction

    // called at a falling edge; returns at a falling edge once the beat is taken and busy is low
    task automatic send_cmd(input t_op op, input t_value value);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        = 1'b1;
        i_operation  = op;
        i_push_value = value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
        if (op == OP_PUSH && depth_now < DEPTH)
            depth_now++;
        else if (op == OP_POP && depth_now > 0)
            depth_now--;
    endtask

    initial begin
        int sent;
        int mode;
        int chunk;
        int err_pick;
        start        = 1'b0;
        i_operation  = OP_PUSH;
        i_push_value = '0;
        i_rst_n      = 1'b0;
        depth_now    = 0;
        no_idle      = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_cmd(OP_DUMP, '0);
        send_cmd(OP_SPARE_LO, 32'sh1234_5678);
        send_cmd(OP_SPARE_MID, '1);
        send_cmd(OP_SPARE_HI, '0);
        send_cmd(OP_PUSH, 32'sh7FFF_FFFF);
        send_cmd(OP_PEEK, '1);
        send_cmd(OP_PUSH, 32'sh8000_0000);
        send_cmd(OP_PUSH, '0);
        send_cmd(OP_PUSH, '1);
        send_cmd(OP_PUSH, 32'sh0000_0001);
        send_cmd(OP_PEEK, '0);
        send_cmd(OP_SWAP, '0);
        send_cmd(OP_PEEK, '0);
        send_cmd(OP_DUMP, '0);
        send_cmd(OP_POP, '1);
        send_cmd(OP_PEEK, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_SWAP, '0);
        send_cmd(OP_DUMP, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_DUMP, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode    = $urandom_range(MODE_FILL, MODE_MIXED);
            chunk   = $urandom_range(5, 40);
            if (chunk > RANDOM_ITEMS - sent)
                chunk = RANDOM_ITEMS - sent;
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (chunk) begin
                send_cmd(pick_op(mode, depth_now), pick_value());
                sent++;
            end
        end
        no_idle = 1'b0;

        // one terminal error per run, chosen by the seed
        err_pick = $urandom_range(ERR_POP_EMPTY, ERR_PUSH_FULL);
        if (err_pick == ERR_PUSH_FULL) begin
            while (depth_now < DEPTH)
                send_cmd(OP_PUSH, pick_value());
            send_cmd(OP_DUMP, '0);
            send_cmd(OP_PUSH, pick_value());
        end else begin
            while (depth_now > 0)
                send_cmd(OP_POP, pick_value());
            if (err_pick == ERR_POP_EMPTY) begin
                send_cmd(OP_POP, '0);
            end else if (err_pick == ERR_PEEK_EMPTY) begin
                send_cmd(OP_PEEK, '0);
            end else begin
                if ($urandom_range(0, 1) == 1)
                    send_cmd(OP_PUSH, pick_value());
                send_cmd(OP_SWAP, '0);
            end
        end

        // halted: all of these must be ignored
        send_cmd(OP_PUSH, pick_value());
        send_cmd(OP_PEEK, '0);
        send_cmd(OP_DUMP, '0);
        repeat (10)
            send_cmd(t_op'($urandom_range(OP_PUSH, OP_SPARE_HI)), pick_value());
        start = 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
